// ----- rtl/min_heap_priority_queue_top_macros.svh -----
// Assertion macros shared by the min-heap priority queue RTL.
// Depends on nothing; users must have clk and rst in scope.
`ifndef MIN_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH
`define MIN_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MHPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mhpq_pkg.sv -----
// Package for the min-heap priority queue: sizes, codes, item and control types.
// Depends on nothing.
package mhpq_pkg;

  localparam int HEAP_DEPTH = 32;
  localparam int ADDR_W     = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int CHILD_W    = ADDR_W + 2;
  localparam int KEY_W      = 32;
  localparam int ENTRY_W    = 6;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic                    command;
    logic signed [KEY_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] removed_value;
    status_t                 status;
    logic [ENTRY_W-1:0]      entry_count;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic start_ins;
    logic set_full;
    logic set_empty;
    logic rd_parent;
    logic rd_ends;
    logic rd_children;
    logic dn_take;
    logic up_place;
    logic up_step;
    logic dn_step;
    logic load_out;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic at_root;
    logic up_move;
    logic dn_move;
    logic cnt_zero;
  } stat_t;

endpackage

// ----- rtl/mhpq_ram.sv -----
// Generic RAM: one write port, two registered read ports.
// Depends on nothing.
module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- rtl/mhpq_ctrl.sv -----
// Controller for the min-heap priority queue: sequences insert and delete.
// Depends on mhpq_pkg and min_heap_priority_queue_top_macros.svh.
`include "min_heap_priority_queue_top_macros.svh"

module mhpq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_command,
  output logic             req_stall,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  input  mhpq_pkg::stat_t  stat,
  output mhpq_pkg::cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_READ,
    S_UP_CMP,
    S_DN_FETCH,
    S_DN_TAKE,
    S_DN_READ,
    S_DN_CMP,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req_command == mhpq_pkg::CMD_DELETE) begin
            if (stat.empty) begin
              cmd.set_empty = 1'b1;
              state_next    = S_DONE;
            end else begin
              state_next = S_DN_FETCH;
            end
          end else if (stat.full) begin
            cmd.set_full = 1'b1;
            state_next   = S_DONE;
          end else begin
            cmd.start_ins = 1'b1;
            state_next    = S_UP_READ;
          end
        end
      end
      S_UP_READ: begin
        if (stat.at_root) begin
          cmd.up_place = 1'b1;
          state_next   = S_DONE;
        end else begin
          cmd.rd_parent = 1'b1;
          state_next    = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd.up_step = 1'b1;
        state_next  = stat.up_move ? S_UP_READ : S_DONE;
      end
      S_DN_FETCH: begin
        cmd.rd_ends = 1'b1;
        state_next  = S_DN_TAKE;
      end
      S_DN_TAKE: begin
        cmd.dn_take = 1'b1;
        state_next  = S_DN_READ;
      end
      S_DN_READ: begin
        if (stat.cnt_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.rd_children = 1'b1;
          state_next      = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        cmd.dn_step = 1'b1;
        state_next  = stat.dn_move ? S_DN_READ : S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `MHPQ_ASSERT_NEXT(a_accept_leaves_idle, req_valid && !req_stall, state != S_IDLE,
    "accepted item did not start work")
  `MHPQ_ASSERT_NOW(a_load_into_free_slot, cmd.load_out, !rsp_valid || !rsp_stall,
    "result loaded over a stalled result")
  `MHPQ_ASSERT_NEXT(a_drain_clears_valid, rsp_valid && !rsp_stall && !cmd.load_out,
    !rsp_valid, "taken result shown again")

endmodule

// ----- rtl/mhpq_dp.sv -----
// Datapath for the min-heap priority queue: heap RAM, hole position, key, count,
// result register. Depends on mhpq_pkg, mhpq_ram and the macros header.
`include "min_heap_priority_queue_top_macros.svh"

module mhpq_dp (
  input  logic            clk,
  input  logic            rst,
  input  mhpq_pkg::req_t  req,
  input  mhpq_pkg::cmd_t  cmd,
  output mhpq_pkg::stat_t stat,
  output mhpq_pkg::rsp_t  rsp
);

  logic [mhpq_pkg::CNT_W-1:0]          count;
  logic [mhpq_pkg::ADDR_W-1:0]         pos;
  logic signed [mhpq_pkg::KEY_W-1:0]   key;
  logic signed [mhpq_pkg::KEY_W-1:0]   removed;
  mhpq_pkg::status_t                   status;

  logic [mhpq_pkg::ADDR_W-1:0]         parent;
  logic [mhpq_pkg::CHILD_W-1:0]        left;
  logic [mhpq_pkg::CHILD_W-1:0]        right;
  logic [mhpq_pkg::ADDR_W-1:0]         raddr_a;
  logic [mhpq_pkg::ADDR_W-1:0]         raddr_b;
  logic [mhpq_pkg::KEY_W-1:0]          rdata_a;
  logic [mhpq_pkg::KEY_W-1:0]          rdata_b;
  logic                                we;
  logic signed [mhpq_pkg::KEY_W-1:0]   wdata;
  logic                                left_ok;
  logic                                right_ok;
  logic                                take_left;
  logic                                take_right;
  logic signed [mhpq_pkg::KEY_W-1:0]   cand;
  logic signed [mhpq_pkg::KEY_W-1:0]   best_val;
  logic [mhpq_pkg::ADDR_W-1:0]         best_pos;

  assign parent = (pos - mhpq_pkg::ADDR_W'(1)) >> 1;
  assign left   = {1'b0, pos, 1'b1};
  assign right  = {1'b0, pos, 1'b0} + mhpq_pkg::CHILD_W'(2);

  // Pick the smaller child; the left one wins a tie.
  assign left_ok    = left < mhpq_pkg::CHILD_W'(count);
  assign right_ok   = right < mhpq_pkg::CHILD_W'(count);
  assign take_left  = left_ok && ($signed(rdata_a) < key);
  assign cand       = take_left ? $signed(rdata_a) : key;
  assign take_right = right_ok && ($signed(rdata_b) < cand);
  assign best_val   = take_right ? $signed(rdata_b) : $signed(rdata_a);
  assign best_pos   = take_right ? right[mhpq_pkg::ADDR_W-1:0]
                                 : left[mhpq_pkg::ADDR_W-1:0];

  assign stat.full     = count >= mhpq_pkg::CNT_W'(mhpq_pkg::HEAP_DEPTH);
  assign stat.empty    = count == '0;
  assign stat.at_root  = pos == '0;
  assign stat.up_move  = key < $signed(rdata_a);
  assign stat.dn_move  = take_left || take_right;
  assign stat.cnt_zero = count == '0;

  always_comb begin
    raddr_a = '0;
    raddr_b = '0;
    if (cmd.rd_parent) begin
      raddr_a = parent;
    end else if (cmd.rd_ends) begin
      raddr_b = mhpq_pkg::ADDR_W'(count - mhpq_pkg::CNT_W'(1));
    end else if (cmd.rd_children) begin
      raddr_a = left[mhpq_pkg::ADDR_W-1:0];
      raddr_b = right[mhpq_pkg::ADDR_W-1:0];
    end
  end

  // The moving key stays in a register; only displaced entries are written
  // into the hole, and the key lands once its slot is found.
  always_comb begin
    we    = cmd.up_place || cmd.up_step || cmd.dn_step;
    wdata = key;
    if (cmd.up_step && stat.up_move) begin
      wdata = $signed(rdata_a);
    end else if (cmd.dn_step && stat.dn_move) begin
      wdata = best_val;
    end
  end

  mhpq_ram #(
    .WIDTH(mhpq_pkg::KEY_W),
    .DEPTH(mhpq_pkg::HEAP_DEPTH)
  ) u_heap_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (pos),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.start_ins) begin
      count <= count + mhpq_pkg::CNT_W'(1);
    end else if (cmd.dn_take) begin
      count <= count - mhpq_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_ins) begin
      key     <= req.value;
      pos     <= mhpq_pkg::ADDR_W'(count);
      removed <= '0;
      status  <= mhpq_pkg::ST_DONE;
    end else if (cmd.set_full) begin
      removed <= '0;
      status  <= mhpq_pkg::ST_FULL;
    end else if (cmd.set_empty) begin
      removed <= '0;
      status  <= mhpq_pkg::ST_EMPTY;
    end else if (cmd.dn_take) begin
      removed <= $signed(rdata_a);
      key     <= $signed(rdata_b);
      pos     <= '0;
      status  <= mhpq_pkg::ST_DONE;
    end else if (cmd.up_step && stat.up_move) begin
      pos <= parent;
    end else if (cmd.dn_step && stat.dn_move) begin
      pos <= best_pos;
    end
    if (cmd.load_out) begin
      rsp.removed_value <= removed;
      rsp.status        <= status;
      rsp.entry_count   <= mhpq_pkg::ENTRY_W'(count);
    end
  end

  `MHPQ_ASSERT_NOW(a_count_in_range, 1'b1,
    count <= mhpq_pkg::CNT_W'(mhpq_pkg::HEAP_DEPTH), "entry count beyond depth")
  `MHPQ_ASSERT_NOW(a_up_move_not_root, cmd.up_step, pos != '0,
    "sift-up compare at the root")
  `MHPQ_ASSERT_NOW(a_take_nonempty, cmd.dn_take, count != '0,
    "delete taken from an empty heap")

endmodule

// ----- rtl/min_heap_priority_queue_top.sv -----
// Top level of the min-heap priority queue: controller plus datapath.
// Depends on mhpq_pkg, mhpq_ctrl, mhpq_dp (and mhpq_ram below it).
//
//   channel | signals                        | payload
//   --------+--------------------------------+----------------------------------
//   request | req_valid in, req_stall out    | command, value
//   result  | rsp_valid out, rsp_stall in    | removed_value, status, entry_count
//
// One item at a time. Insert climbs the key one level at a time until it stops
// below its parent or reaches the root. Delete takes the root and, unless it
// took the last entry, sinks the last entry from the root level by level. Full
// and empty items go straight to the result. Each level costs one heap RAM read
// and one compare-and-write; the RAM read port is registered.
// Reset clears the entry count and the handshakes; heap contents need no clear.
// A stalled result holds in its register while the next item is accepted and
// worked; that item waits for the register to free before it finishes.
module min_heap_priority_queue_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  mhpq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output mhpq_pkg::rsp_t rsp
);

  mhpq_pkg::cmd_t  cmd;
  mhpq_pkg::stat_t stat;

  // Sequence each operation.
  mhpq_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_command (req.command),
    .req_stall   (req_stall),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  // Hold the heap, the moving key and the result register.
  mhpq_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule

// ----- tb/tb_min_heap_priority_queue_top.sv -----
// Self-checking testbench for min_heap_priority_queue_top: random and directed
// insert/delete-min traffic checked against a behavioral heap kept alongside.
// Depends on mhpq_pkg and the min_heap_priority_queue_top RTL.
module tb_min_heap_priority_queue_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_OPS    = 1530;
  localparam int DRAIN_CYCLES  = 20;
  localparam int LONG_HOLD     = 300;
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    mhpq_pkg::req_t op;
    bit             drain_first;   // hold this item until every result is back
  } send_slot_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  mhpq_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  mhpq_pkg::rsp_t rsp;

  // Behavioral heap that tracks what the block should hold.
  logic signed [mhpq_pkg::KEY_W-1:0] heap_keys [mhpq_pkg::HEAP_DEPTH];
  int                                heap_len = 0;

  send_slot_t     ops_to_send [$];
  mhpq_pkg::rsp_t awaited_rsp [$];
  int             total_ops = 0;
  int             n_offered = 0;
  int             n_accepted = 0;
  int             mismatches = 0;
  int             cycles = 0;
  int             send_gap = 0;
  int             rsp_hold_left = 0;
  int             long_holds = 0;

  min_heap_priority_queue_top DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // Apply one operation to the behavioral heap and return the result it owes.
  function automatic mhpq_pkg::rsp_t heap_apply(mhpq_pkg::req_t op);
    mhpq_pkg::rsp_t                    res;
    int                                pos;
    int                                par;
    int                                lft;
    int                                rgt;
    int                                best;
    bit                                moving;
    logic signed [mhpq_pkg::KEY_W-1:0] tmp;
    res.removed_value = '0;
    res.status        = mhpq_pkg::ST_DONE;
    if (op.command == mhpq_pkg::CMD_INSERT) begin
      if (heap_len >= mhpq_pkg::HEAP_DEPTH) begin
        res.status = mhpq_pkg::ST_FULL;
      end else begin
        // append, then climb while strictly smaller than the parent
        heap_keys[heap_len] = op.value;
        pos = heap_len;
        heap_len++;
        moving = 1'b1;
        while (moving && pos > 0) begin
          par = (pos - 1) / 2;
          if (heap_keys[pos] < heap_keys[par]) begin
            tmp = heap_keys[pos];
            heap_keys[pos] = heap_keys[par];
            heap_keys[par] = tmp;
            pos = par;
          end else begin
            moving = 1'b0;
          end
        end
      end
    end else begin
      if (heap_len == 0) begin
        res.status = mhpq_pkg::ST_EMPTY;
      end else begin
        res.removed_value = heap_keys[0];
        heap_len--;
        if (heap_len > 0) begin
          // move the last entry to the root and sink it; left child wins a tie
          heap_keys[0] = heap_keys[heap_len];
          pos = 0;
          moving = 1'b1;
          while (moving) begin
            lft  = 2 * pos + 1;
            rgt  = 2 * pos + 2;
            best = pos;
            if (lft < heap_len && heap_keys[lft] < heap_keys[best]) best = lft;
            if (rgt < heap_len && heap_keys[rgt] < heap_keys[best]) best = rgt;
            if (best == pos) begin
              moving = 1'b0;
            end else begin
              tmp = heap_keys[pos];
              heap_keys[pos] = heap_keys[best];
              heap_keys[best] = tmp;
              pos = best;
            end
          end
        end
      end
    end
    res.entry_count = mhpq_pkg::ENTRY_W'(heap_len);
    return res;
  endfunction

  // Key mix: full-range random, a narrow band that forces ties, and the extremes.
  function automatic logic signed [mhpq_pkg::KEY_W-1:0] rand_key();
    logic signed [mhpq_pkg::KEY_W-1:0] k;
    case ($urandom_range(0, 9))
      5, 6, 7: k = int'($urandom_range(0, 15)) - 8;
      8: begin
        case ($urandom_range(0, 3))
          0:       k = 32'sh7FFF_FFFF;
          1:       k = 32'sh8000_0000;
          2:       k = '0;
          default: k = '1;
        endcase
      end
      default: k = $urandom;
    endcase
    return k;
  endfunction

  // Idle length: mostly none or short, now and then a long one.
  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 9);
    return $urandom_range(15, 40);
  endfunction

  function automatic void add_op(logic cmd, logic signed [mhpq_pkg::KEY_W-1:0] key,
                                 bit drain);
    send_slot_t s;
    s.op.command  = cmd;
    s.op.value    = key;
    s.drain_first = drain;
    ops_to_send.push_back(s);
    total_ops++;
  endfunction

  function automatic void note_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", what);
  endfunction

  // Sender: present a new item only once the last one was taken, and hold
  // the payload steady while the block stalls it.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && n_accepted != n_offered) begin
      req_valid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap  <= send_gap - 1;
      req_valid <= 1'b0;
    end else if (ops_to_send.size() > 0 &&
                 (!ops_to_send[0].drain_first || awaited_rsp.size() == 0)) begin
      req       <= ops_to_send[0].op;
      req_valid <= 1'b1;
      n_offered <= n_offered + 1;
      // quiet stretches send back to back
      send_gap  <= ((n_offered / 150) % 5 == 2) ? 0 : next_gap();
      void'(ops_to_send.pop_front());
    end else begin
      req_valid <= 1'b0;
    end
  end

  // Receiver: random short stalls, quiet stretches, and two long hold-offs
  // that back the block up until it stalls its own input.
  always @(negedge clk) begin
    if (rsp_hold_left > 0) begin
      rsp_hold_left <= rsp_hold_left - 1;
      rsp_stall     <= 1'b1;
    end else if (long_holds < 2 && n_accepted >= 500 * (long_holds + 1)) begin
      long_holds    <= long_holds + 1;
      rsp_hold_left <= LONG_HOLD - 1;
      rsp_stall     <= 1'b1;
    end else if ((cycles / 700) % 5 != 3 && $urandom_range(0, 3) == 0) begin
      rsp_hold_left <= next_gap();
      rsp_stall     <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Predict on every accepted item, then check every accepted result
  // against the oldest prediction.
  always @(posedge clk) begin
    mhpq_pkg::rsp_t want;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        awaited_rsp.push_back(heap_apply(req));
        n_accepted <= n_accepted + 1;
      end
      if (rsp_valid && !rsp_stall) begin
        if (awaited_rsp.size() == 0) begin
          note_mismatch($sformatf("unexpected result: removed %0d status %0d count %0d",
                                  rsp.removed_value, rsp.status, rsp.entry_count));
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp.removed_value !== want.removed_value)
            note_mismatch($sformatf("removed_value: expected %0d, got %0d",
                                    want.removed_value, rsp.removed_value));
          if (rsp.status !== want.status)
            note_mismatch($sformatf("status: expected %0d, got %0d",
                                    want.status, rsp.status));
          if (rsp.entry_count !== want.entry_count)
            note_mismatch($sformatf("entry_count: expected %0d, got %0d",
                                    want.entry_count, rsp.entry_count));
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("min_heap_priority_queue_top: mismatch");
      $finish;
    end
  end

  initial begin
    int burst;
    int len;
    int ins_pct;
    int rand_count;
    logic pick;

    // Directed: delete on empty, delete of the only entry, key extremes,
    // ties among children, then drain back to empty.
    add_op(mhpq_pkg::CMD_DELETE, '0, 1'b0);
    add_op(mhpq_pkg::CMD_INSERT, 32'sh7FFF_FFFF, 1'b0);
    add_op(mhpq_pkg::CMD_DELETE, '1, 1'b0);
    add_op(mhpq_pkg::CMD_DELETE, 32'sh5555_AAAA, 1'b0);
    add_op(mhpq_pkg::CMD_INSERT, 32'sh8000_0000, 1'b0);
    add_op(mhpq_pkg::CMD_INSERT, 32'sh7FFF_FFFF, 1'b0);
    add_op(mhpq_pkg::CMD_INSERT, 32'sh0000_0000, 1'b0);
    add_op(mhpq_pkg::CMD_INSERT, -32'sd1, 1'b0);
    add_op(mhpq_pkg::CMD_INSERT, 32'sd1, 1'b0);
    add_op(mhpq_pkg::CMD_INSERT, -32'sd1, 1'b0);
    add_op(mhpq_pkg::CMD_INSERT, 32'sd5, 1'b0);
    add_op(mhpq_pkg::CMD_INSERT, 32'sd5, 1'b0);
    add_op(mhpq_pkg::CMD_INSERT, 32'sd5, 1'b0);
    for (int i = 0; i < 11; i++) add_op(mhpq_pkg::CMD_DELETE, rand_key(), 1'b0);

    // Random bursts with a bias toward insert or delete, so the heap swings
    // between full and empty; some bursts wait for the pipe to drain first.
    burst = 0;
    rand_count = 0;
    while (rand_count < RANDOM_OPS) begin
      len = (burst == 0) ? 40 : $urandom_range(20, 80);
      if (burst == 0 || burst % 6 == 3) begin
        ins_pct = 100;
      end else begin
        case ($urandom_range(0, 2))
          0:       ins_pct = 90;
          1:       ins_pct = 50;
          default: ins_pct = 15;
        endcase
      end
      for (int i = 0; i < len; i++) begin
        pick = ($urandom_range(0, 99) < ins_pct) ? mhpq_pkg::CMD_INSERT
                                                 : mhpq_pkg::CMD_DELETE;
        add_op(pick, rand_key(), i == 0 && burst % 5 == 4);
      end
      rand_count += len;
      burst++;
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for every item to be taken and every result to come back.
    while (ops_to_send.size() != 0 || n_accepted != total_ops || awaited_rsp.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && awaited_rsp.size() == 0) begin
      $display("min_heap_priority_queue_top: match");
    end else begin
      $display("min_heap_priority_queue_top: mismatch");
    end
    $finish;
  end

endmodule
